@@ rtl/core/nfha_pkg.sv @@
// Shared constants for the next-fit heap allocator.
// Default heap geometry; no dependencies.
package nfha_pkg;

  localparam int unsigned HEAP_BYTES_DEF        = 65536;
  localparam int unsigned HEADER_BYTES_DEF      = 16;
  localparam int unsigned HEAP_HEADER_BYTES_DEF = 32;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

endpackage

@@ rtl/core/next_fit_heap_allocator_top.sv @@
// Next-fit heap allocator: block table kept as a linked list in one node RAM,
// with a recycled-node stack RAM. Depends on nfha_pkg.
//
// Usage: an item on in_* (action, request_bytes, block_offset) is accepted when
// in_valid is high and in_stall is low. Each item gives exactly one result on
// out_* (data_offset, ok, byte and block totals), held while out_stall is high.
// An item occupies the block from acceptance until its result is loaded into
// the output register; in_stall stays high meanwhile. Latency depends on the
// heap contents and is set by walks over the node RAM: a free walks the block
// list in S_F1 from the lowest block up to the target, plus up to three
// next-fit searches; a next-fit search reads the node RAM in states S_SR0 and
// S_SR1, one node per pass. An allocation steps the next-fit position for at
// most one pass over the free blocks. A hit at the next-fit block with a split
// passes S_A1, S_SPL0 if a recycled node is popped, S_SPL1 and S_SPL2 before
// S_DONE loads the result and raises out_valid.
// After reset the S_INIT state writes the initial free block; in_stall is high then.
// A result that waits under out_stall holds the block before its output stage,
// so the next item can be taken while the last result still waits only once
// that result is gone from the finish state.
module next_fit_heap_allocator_top #(
  parameter int unsigned HEAP_BYTES        = nfha_pkg::HEAP_BYTES_DEF,
  parameter int unsigned HEADER_BYTES      = nfha_pkg::HEADER_BYTES_DEF,
  parameter int unsigned HEAP_HEADER_BYTES = nfha_pkg::HEAP_HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [15:0] in_request_bytes,
  input  logic [15:0] in_block_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_data_offset,
  output logic        out_ok,
  output logic [16:0] out_free_bytes,
  output logic [16:0] out_used_bytes,
  output logic [12:0] out_free_blocks,
  output logic [12:0] out_used_blocks
);

  localparam int unsigned MAX_BLOCKS = (HEAP_BYTES - HEAP_HEADER_BYTES) / HEADER_BYTES + 1;
  localparam int unsigned NW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW = $clog2(HEAP_BYTES + 1);
  localparam int unsigned XW = ((AW > 16) ? AW : 16) + 1;
  localparam logic [AW-1:0] HB = AW'(HEADER_BYTES);

  localparam logic [4:0] S_INIT = 5'd0,  S_IDLE = 5'd1,  S_A1   = 5'd2,  S_ANXT = 5'd3,
                         S_SPL0 = 5'd4,  S_SPL1 = 5'd5,  S_SPL2 = 5'd6,  S_F1   = 5'd7,
                         S_F2   = 5'd8,  S_F3   = 5'd9,  S_F4   = 5'd10, S_F5   = 5'd11,
                         S_F6   = 5'd12, S_SR0  = 5'd13, S_SR1  = 5'd14, S_DONE = 5'd15;

  localparam logic [1:0] PH_FIRST = 2'd0, PH_ABOVE = 2'd1, PH_WRAP = 2'd2;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [AW-1:0] data;
    logic          free;
    logic          hn;
    logic [NW-1:0] nxt;
  } node_t;

  node_t         mem [MAX_BLOCKS];
  logic [NW-1:0] stk [MAX_BLOCKS];

  node_t         rdq, wd;
  logic          re, we, sre, swe;
  logic [NW-1:0] ra, wa, sra, swa, swd, stkq;

  logic [4:0]    st_r, st_nxt, ret_r, ret_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic [NW-1:0] cur_r, cur_nxt, prv_r, prv_nxt, fit_r, fit_nxt, sidx_r, sidx_nxt;
  logic [NW-1:0] new_r, new_nxt;
  logic          prv_v_r, prv_v_nxt, fit_v_r, fit_v_nxt;
  node_t         nd_r, nd_nxt, pnd_r, pnd_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt, ucnt_r, ucnt_nxt, hw_r, hw_nxt, sp_r, sp_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] fb_r, fb_nxt, ub_r, ub_nxt, where_r, where_nxt;
  logic          ok_r, ok_nxt, act_r, act_nxt;
  logic [15:0]   req_r, req_nxt, off_r, off_nxt;
  logic          out_v_r, out_v_nxt;
  logic [15:0]   o_off_r, o_off_nxt;
  logic          o_ok_r, o_ok_nxt;
  logic [16:0]   o_fb_r, o_fb_nxt, o_ub_r, o_ub_nxt;
  logic [12:0]   o_fc_r, o_fc_nxt, o_uc_r, o_uc_nxt;
  logic [AW-1:0] merged;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdq <= mem[ra];
    end
    if (swe) begin
      stk[swa] <= swd;
    end
    if (sre) begin
      stkq <= stk[sra];
    end
  end

  assign merged = pnd_r.data + nd_r.data + HB;

  always_comb begin
    st_nxt = st_r;  ret_nxt = ret_r;  ph_nxt = ph_r;
    cur_nxt = cur_r;  prv_nxt = prv_r;  fit_nxt = fit_r;  sidx_nxt = sidx_r;
    new_nxt = new_r;  prv_v_nxt = prv_v_r;  fit_v_nxt = fit_v_r;
    nd_nxt = nd_r;  pnd_nxt = pnd_r;
    fcnt_nxt = fcnt_r;  ucnt_nxt = ucnt_r;  hw_nxt = hw_r;  sp_nxt = sp_r;  n_nxt = n_r;
    fb_nxt = fb_r;  ub_nxt = ub_r;  where_nxt = where_r;  ok_nxt = ok_r;  act_nxt = act_r;
    req_nxt = req_r;  off_nxt = off_r;
    out_v_nxt = out_v_r;  o_off_nxt = o_off_r;  o_ok_nxt = o_ok_r;
    o_fb_nxt = o_fb_r;  o_ub_nxt = o_ub_r;  o_fc_nxt = o_fc_r;  o_uc_nxt = o_uc_r;
    re = 1'b0;  ra = '0;  we = 1'b0;  wa = '0;  wd = rdq;
    sre = 1'b0;  sra = '0;  swe = 1'b0;  swa = '0;  swd = '0;

    if (out_v_r && !out_stall) begin
      out_v_nxt = 1'b0;
    end

    unique case (st_r)
      S_INIT: begin
        we = 1'b1;
        wa = '0;
        wd = '{start: AW'(HEAP_HEADER_BYTES),
               data: AW'(HEAP_BYTES - HEAP_HEADER_BYTES - HEADER_BYTES),
               free: 1'b1, hn: 1'b0, nxt: '0};
        st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action;
          req_nxt = in_request_bytes;
          off_nxt = in_block_offset;
          where_nxt = '0;
          ok_nxt = 1'b0;
          if (in_action == nfha_pkg::ACT_FREE) begin
            re = 1'b1;
            ra = '0;
            cur_nxt = '0;
            prv_v_nxt = 1'b0;
            st_nxt = S_F1;
          end else if (!fit_v_r) begin
            st_nxt = S_DONE;
          end else begin
            re = 1'b1;
            ra = fit_r;
            n_nxt = fcnt_r;
            st_nxt = S_A1;
          end
        end
      end
      S_A1: begin
        cur_nxt = fit_r;
        nd_nxt = rdq;
        if (XW'(rdq.data) == XW'(req_r)) begin
          we = 1'b1;
          wa = fit_r;
          wd = rdq;
          wd.free = 1'b0;
          fcnt_nxt = fcnt_r - 1'b1;
          fb_nxt = fb_r - rdq.data;
          ucnt_nxt = ucnt_r + 1'b1;
          ub_nxt = ub_r + AW'(req_r);
          where_nxt = rdq.start + HB;
          ok_nxt = 1'b1;
          sidx_nxt = fit_r;
          ph_nxt = PH_FIRST;
          ret_nxt = S_DONE;
          st_nxt = S_SR0;
        end else if (XW'(rdq.data) >= XW'(req_r) + XW'(HEADER_BYTES) &&
                     (CW + 1)'(fcnt_r) + (CW + 1)'(ucnt_r) < (CW + 1)'(MAX_BLOCKS)) begin
          where_nxt = rdq.start + HB;
          if (sp_r != '0) begin
            sre = 1'b1;
            sra = NW'(sp_r - 1'b1);
            sp_nxt = sp_r - 1'b1;
            st_nxt = S_SPL0;
          end else begin
            new_nxt = hw_r[NW-1:0];
            hw_nxt = hw_r + 1'b1;
            st_nxt = S_SPL1;
          end
        end else begin
          n_nxt = n_r - 1'b1;
          sidx_nxt = fit_r;
          ph_nxt = PH_FIRST;
          ret_nxt = S_ANXT;
          st_nxt = S_SR0;
        end
      end
      S_ANXT: begin
        if (n_r == '0 || !fit_v_r) begin
          st_nxt = S_DONE;
        end else begin
          re = 1'b1;
          ra = fit_r;
          st_nxt = S_A1;
        end
      end
      S_SPL0: begin
        new_nxt = stkq;
        st_nxt = S_SPL1;
      end
      S_SPL1: begin
        we = 1'b1;
        wa = new_r;
        wd = '{start: nd_r.start + HB + AW'(req_r),
               data: nd_r.data - AW'(req_r) - HB,
               free: 1'b1, hn: nd_r.hn, nxt: nd_r.nxt};
        st_nxt = S_SPL2;
      end
      S_SPL2: begin
        we = 1'b1;
        wa = cur_r;
        wd = '{start: nd_r.start, data: AW'(req_r), free: 1'b0, hn: 1'b1, nxt: new_r};
        fb_nxt = fb_r - AW'(req_r) - HB;
        ucnt_nxt = ucnt_r + 1'b1;
        ub_nxt = ub_r + AW'(req_r);
        fit_nxt = new_r;
        fit_v_nxt = 1'b1;
        ok_nxt = 1'b1;
        st_nxt = S_DONE;
      end
      S_F1: begin
        if (!rdq.free && XW'(rdq.start) + XW'(HEADER_BYTES) == XW'(off_r)) begin
          nd_nxt = rdq;
          ucnt_nxt = ucnt_r - 1'b1;
          ub_nxt = ub_r - rdq.data;
          ok_nxt = 1'b1;
          if (rdq.hn) begin
            re = 1'b1;
            ra = rdq.nxt;
            st_nxt = S_F2;
          end else begin
            st_nxt = S_F3;
          end
        end else if (rdq.hn) begin
          prv_nxt = cur_r;
          pnd_nxt = rdq;
          prv_v_nxt = 1'b1;
          cur_nxt = rdq.nxt;
          re = 1'b1;
          ra = rdq.nxt;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_F2: begin
        st_nxt = S_F3;
        if (rdq.free) begin
          fcnt_nxt = fcnt_r - 1'b1;
          fb_nxt = fb_r - rdq.data;
          we = 1'b1;
          wa = nd_r.nxt;
          wd = rdq;
          wd.free = 1'b0;
          nd_nxt.data = nd_r.data + rdq.data + HB;
          nd_nxt.nxt = rdq.nxt;
          nd_nxt.hn = rdq.hn;
          swe = 1'b1;
          swa = sp_r[NW-1:0];
          swd = nd_r.nxt;
          sp_nxt = sp_r + 1'b1;
          if (fit_v_r && fit_r == nd_r.nxt) begin
            sidx_nxt = nd_r.nxt;
            ph_nxt = PH_FIRST;
            ret_nxt = S_F3;
            st_nxt = S_SR0;
          end
        end
      end
      S_F3: begin
        if (fcnt_r == '0) begin
          fit_nxt = cur_r;
          fit_v_nxt = 1'b1;
        end
        fcnt_nxt = fcnt_r + 1'b1;
        fb_nxt = fb_r + nd_r.data;
        we = 1'b1;
        wa = cur_r;
        wd = nd_r;
        wd.free = 1'b1;
        st_nxt = (prv_v_r && pnd_r.free) ? S_F4 : S_DONE;
      end
      S_F4: begin
        fcnt_nxt = fcnt_r - 1'b1;
        fb_nxt = fb_r - nd_r.data;
        we = 1'b1;
        wa = cur_r;
        wd = nd_r;
        wd.free = 1'b0;
        st_nxt = S_F5;
        if (fit_v_r && fit_r == cur_r) begin
          sidx_nxt = cur_r;
          ph_nxt = PH_FIRST;
          ret_nxt = S_F5;
          st_nxt = S_SR0;
        end
      end
      S_F5: begin
        fcnt_nxt = fcnt_r - 1'b1;
        fb_nxt = fb_r - pnd_r.data;
        we = 1'b1;
        wa = prv_r;
        wd = pnd_r;
        wd.free = 1'b0;
        st_nxt = S_F6;
        if (fit_v_r && fit_r == prv_r) begin
          sidx_nxt = prv_r;
          ph_nxt = PH_FIRST;
          ret_nxt = S_F6;
          st_nxt = S_SR0;
        end
      end
      S_F6: begin
        we = 1'b1;
        wa = prv_r;
        wd = '{start: pnd_r.start, data: merged, free: 1'b1, hn: nd_r.hn, nxt: nd_r.nxt};
        swe = 1'b1;
        swa = sp_r[NW-1:0];
        swd = cur_r;
        sp_nxt = sp_r + 1'b1;
        if (fcnt_r == '0) begin
          fit_nxt = prv_r;
          fit_v_nxt = 1'b1;
        end
        fcnt_nxt = fcnt_r + 1'b1;
        fb_nxt = fb_r + merged;
        st_nxt = S_DONE;
      end
      S_SR0: begin
        re = 1'b1;
        ra = sidx_r;
        st_nxt = S_SR1;
      end
      S_SR1: begin
        st_nxt = S_SR0;
        if (ph_r == PH_FIRST) begin
          if (rdq.hn) begin
            sidx_nxt = rdq.nxt;
            ph_nxt = PH_ABOVE;
          end else begin
            sidx_nxt = '0;
            ph_nxt = PH_WRAP;
          end
        end else if (rdq.free) begin
          fit_nxt = sidx_r;
          fit_v_nxt = 1'b1;
          st_nxt = ret_r;
        end else if (rdq.hn) begin
          sidx_nxt = rdq.nxt;
        end else if (ph_r == PH_ABOVE) begin
          sidx_nxt = '0;
          ph_nxt = PH_WRAP;
        end else begin
          fit_v_nxt = 1'b0;
          st_nxt = ret_r;
        end
      end
      S_DONE: begin
        if (!out_v_r || !out_stall) begin
          out_v_nxt = 1'b1;
          o_off_nxt = ok_r ? 16'(where_r) : '0;
          o_ok_nxt = ok_r;
          o_fb_nxt = 17'(fb_r);
          o_ub_nxt = 17'(ub_r);
          o_fc_nxt = 13'(fcnt_r);
          o_uc_nxt = 13'(ucnt_r);
          st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_INIT;
      fit_r   <= '0;
      fit_v_r <= 1'b1;
      fcnt_r  <= CW'(1);
      ucnt_r  <= '0;
      fb_r    <= AW'(HEAP_BYTES - HEAP_HEADER_BYTES - HEADER_BYTES);
      ub_r    <= '0;
      hw_r    <= CW'(1);
      sp_r    <= '0;
      out_v_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      fit_r   <= fit_nxt;
      fit_v_r <= fit_v_nxt;
      fcnt_r  <= fcnt_nxt;
      ucnt_r  <= ucnt_nxt;
      fb_r    <= fb_nxt;
      ub_r    <= ub_nxt;
      hw_r    <= hw_nxt;
      sp_r    <= sp_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt;  ph_r <= ph_nxt;  cur_r <= cur_nxt;  prv_r <= prv_nxt;
    sidx_r <= sidx_nxt;  new_r <= new_nxt;  prv_v_r <= prv_v_nxt;
    nd_r <= nd_nxt;  pnd_r <= pnd_nxt;  n_r <= n_nxt;
    where_r <= where_nxt;  ok_r <= ok_nxt;  act_r <= act_nxt;
    req_r <= req_nxt;  off_r <= off_nxt;
    o_off_r <= o_off_nxt;  o_ok_r <= o_ok_nxt;  o_fb_r <= o_fb_nxt;
    o_ub_r <= o_ub_nxt;  o_fc_r <= o_fc_nxt;  o_uc_r <= o_uc_nxt;
  end

  assign in_stall        = (st_r != S_IDLE);
  assign out_valid       = out_v_r;
  assign out_data_offset = o_off_r;
  assign out_ok          = o_ok_r;
  assign out_free_bytes  = o_fb_r;
  assign out_used_bytes  = o_ub_r;
  assign out_free_blocks = o_fc_r;
  assign out_used_blocks = o_uc_r;

  a_tiling: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> (int'(fb_r) + int'(ub_r) +
      int'(HEADER_BYTES) * (int'(fcnt_r) + int'(ucnt_r)) ==
      int'(HEAP_BYTES) - int'(HEAP_HEADER_BYTES)))
    else $error("block sizes do not tile the heap");

  a_fit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> (fit_v_r == (fcnt_r != '0)))
    else $error("next-fit valid disagrees with free count");

  a_node_pool: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> ((CW + 1)'(fcnt_r) + (CW + 1)'(ucnt_r) + (CW + 1)'(sp_r) ==
      (CW + 1)'(hw_r)))
    else $error("node pool leaked");

  a_ok_alloc_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE && ok_r && act_r == nfha_pkg::ACT_ALLOC) |->
      (where_r >= AW'(HEAP_HEADER_BYTES) + HB))
    else $error("allocated offset below first block");

endmodule
